// ===== src/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, tags, header offsets and status codes for the parser blocks.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [7:0] SEARCH_LIMIT_RESET = 8'd100;

    localparam logic [5:0] OFF_RIFF_END = 6'd3;
    localparam logic [5:0] OFF_CH_LO    = 6'd22;
    localparam logic [5:0] OFF_CH_HI    = 6'd23;
    localparam logic [5:0] OFF_RATE_B0  = 6'd24;
    localparam logic [5:0] OFF_RATE_B1  = 6'd25;
    localparam logic [5:0] OFF_RATE_B2  = 6'd26;
    localparam logic [5:0] OFF_RATE_B3  = 6'd27;
    localparam logic [5:0] OFF_BITS_LO  = 6'd34;
    localparam logic [5:0] OFF_BITS_HI  = 6'd35;
    localparam logic [5:0] OFF_TAG_END  = 6'd39;
    localparam logic [5:0] OFF_SIZE_END = 6'd3;

    localparam logic [15:0] CH_MONO  = 16'd1;
    localparam logic [15:0] BITS_8   = 16'd8;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SEARCH  = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4,
        PH_BADRIFF = 3'd5,
        PH_NODATA  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_HDRDONE = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_BADRIFF = 3'd3,
        ST_NODATA  = 3'd4,
        ST_IGNORED = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [1:0]  format_code;
    } t_result;

endpackage

// ===== src/wavhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// WAV header parser input stage
// Registers one input beat and stalls the sender while it cannot move on.
// ----------------------------------------------------------------------------
module wavhp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_file_byte,
    input  logic                i_start_of_file,
    input  logic                i_take,
    output logic                o_valid,
    output wavhp_pkg::t_item    o_item
);
    import wavhp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  c_load;

    assign o_in_stall = r_valid && !i_take;
    assign c_load     = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (c_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_item.file_byte     <= i_file_byte;
            r_item.start_of_file <= i_start_of_file;
        end
    end

endmodule

// ===== src/wavhp_core.sv =====
// ----------------------------------------------------------------------------
// WAV header parser core
// Holds parse state and works out one byte's result per cycle when advanced.
// ----------------------------------------------------------------------------
module wavhp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_search_limit,
    input  logic                i_advance,
    input  wavhp_pkg::t_item    i_item,
    output wavhp_pkg::t_result  o_result
);
    import wavhp_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    logic [5:0]  r_off, n_off, c_off;
    logic [31:0] r_win, n_win, c_win;
    logic [7:0]  r_cnt, n_cnt, c_cnt;
    logic [15:0] r_ch, n_ch, c_ch;
    logic [31:0] r_rate, n_rate, c_rate;
    logic [15:0] r_bits, n_bits, c_bits;
    logic [31:0] r_size, n_size, c_size;
    logic [31:0] r_rem, n_rem, c_rem;
    logic [7:0]  r_search_limit;

    logic [7:0]  c_b;
    logic [31:0] c_win_sh;
    logic        c_riff_bad;
    logic        c_data_hit;
    logic [7:0]  c_cnt_inc;
    logic        c_search_end;
    logic [31:0] c_size_new;
    logic [31:0] c_rem_dec;

    t_status     c_status;
    logic [7:0]  c_pbyte;
    logic        c_plast;

    // A start mark parses its byte against a freshly cleared state.
    always_comb begin
        c_b = i_item.file_byte;
        if (i_item.start_of_file) begin
            c_phase = PH_HEADER;
            c_off   = '0;
            c_win   = '0;
            c_cnt   = '0;
            c_ch    = '0;
            c_rate  = '0;
            c_bits  = '0;
            c_size  = '0;
            c_rem   = '0;
        end else begin
            c_phase = r_phase;
            c_off   = r_off;
            c_win   = r_win;
            c_cnt   = r_cnt;
            c_ch    = r_ch;
            c_rate  = r_rate;
            c_bits  = r_bits;
            c_size  = r_size;
            c_rem   = r_rem;
        end
    end

    always_comb begin
        c_win_sh     = {c_win[23:0], c_b};
        c_riff_bad   = (c_off == OFF_RIFF_END) && (c_win_sh != TAG_RIFF);
        c_data_hit   = (c_win_sh == TAG_DATA);
        c_cnt_inc    = c_cnt + 8'd1;
        c_search_end = (c_cnt_inc >= r_search_limit);
        c_rem_dec    = c_rem - 32'd1;
        c_size_new   = c_size;
        case (c_off[1:0])
            2'd0:    c_size_new[7:0]   = c_size[7:0]   | c_b;
            2'd1:    c_size_new[15:8]  = c_size[15:8]  | c_b;
            2'd2:    c_size_new[23:16] = c_size[23:16] | c_b;
            default: c_size_new[31:24] = c_size[31:24] | c_b;
        endcase
    end

    always_comb begin
        n_phase = c_phase;
        unique case (c_phase)
            PH_HEADER: begin
                if (c_riff_bad) begin
                    n_phase = PH_BADRIFF;
                end else if (c_off == OFF_TAG_END) begin
                    if (c_data_hit) begin
                        n_phase = PH_SIZE;
                    end else if (r_search_limit == 8'd0) begin
                        n_phase = PH_NODATA;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
            end
            PH_SEARCH: begin
                if (c_data_hit) begin
                    n_phase = PH_SIZE;
                end else if (c_search_end) begin
                    n_phase = PH_NODATA;
                end
            end
            PH_SIZE: begin
                if (c_off >= OFF_SIZE_END) begin
                    n_phase = (c_size_new == 32'd0) ? PH_DONE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (c_rem_dec == 32'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    always_comb begin
        c_status = ST_IGNORED;
        c_pbyte  = 8'd0;
        c_plast  = 1'b0;
        unique case (c_phase)
            PH_HEADER: begin
                if (c_riff_bad) begin
                    c_status = ST_BADRIFF;
                end else if ((c_off == OFF_TAG_END) && !c_data_hit
                             && (r_search_limit == 8'd0)) begin
                    c_status = ST_NODATA;
                end else begin
                    c_status = ST_HEADER;
                end
            end
            PH_SEARCH: begin
                c_status = (!c_data_hit && c_search_end) ? ST_NODATA : ST_HEADER;
            end
            PH_SIZE: begin
                c_status = (c_off >= OFF_SIZE_END) ? ST_HDRDONE : ST_HEADER;
            end
            PH_PAYLOAD: begin
                c_status = ST_PAYLOAD;
                c_pbyte  = c_b;
                c_plast  = (c_rem_dec == 32'd0);
            end
            PH_BADRIFF: begin
                c_status = ST_BADRIFF;
            end
            PH_NODATA: begin
                c_status = ST_NODATA;
            end
            default: begin
                c_status = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        n_off  = c_off;
        n_win  = c_win;
        n_cnt  = c_cnt;
        n_ch   = c_ch;
        n_rate = c_rate;
        n_bits = c_bits;
        n_size = c_size;
        n_rem  = c_rem;
        case (c_phase)
            PH_HEADER: begin
                n_win = c_win_sh;
                case (c_off)
                    OFF_CH_LO:   n_ch[7:0]    = c_ch[7:0]    | c_b;
                    OFF_CH_HI:   n_ch[15:8]   = c_ch[15:8]   | c_b;
                    OFF_RATE_B0: n_rate[7:0]  = c_rate[7:0]  | c_b;
                    OFF_RATE_B1: n_rate[15:8] = c_rate[15:8] | c_b;
                    OFF_RATE_B2: n_rate[23:16] = c_rate[23:16] | c_b;
                    OFF_RATE_B3: n_rate[31:24] = c_rate[31:24] | c_b;
                    OFF_BITS_LO: n_bits[7:0]  = c_bits[7:0]  | c_b;
                    OFF_BITS_HI: n_bits[15:8] = c_bits[15:8] | c_b;
                    default:     n_ch         = c_ch;
                endcase
                if (c_riff_bad) begin
                    n_off = c_off;
                end else if (c_off == OFF_TAG_END) begin
                    n_off = '0;
                    n_win = '0;
                    if (!c_data_hit && (r_search_limit != 8'd0)) begin
                        n_cnt = '0;
                    end
                end else begin
                    n_off = c_off + 6'd1;
                end
            end
            PH_SEARCH: begin
                n_win = c_win_sh;
                n_cnt = c_cnt_inc;
                if (c_data_hit) begin
                    n_off = '0;
                end
            end
            PH_SIZE: begin
                n_size = c_size_new;
                if (c_off >= OFF_SIZE_END) begin
                    n_off = '0;
                    n_rem = c_size_new;
                end else begin
                    n_off = c_off + 6'd1;
                end
            end
            PH_PAYLOAD: begin
                n_rem = c_rem_dec;
            end
            default: begin
                n_rem = c_rem;
            end
        endcase
    end

    always_comb begin
        o_result.status          = c_status;
        o_result.payload_byte    = c_pbyte;
        o_result.payload_last    = c_plast;
        o_result.channel_count   = n_ch;
        o_result.sample_rate     = n_rate;
        o_result.bits_per_sample = n_bits;
        o_result.data_size       = n_size;
        o_result.format_code     = {n_ch != CH_MONO, n_bits != BITS_8};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_limit <= SEARCH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_search_limit <= i_cfg_search_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= '0;
            r_win   <= '0;
            r_cnt   <= '0;
            r_ch    <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_size  <= '0;
            r_rem   <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            r_ch    <= n_ch;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_size  <= n_size;
            r_rem   <= n_rem;
        end
    end

`ifndef SYNTHESIS
    a_payload_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != 32'd0))
        else $error("Payload phase entered with no bytes left.");

    a_header_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_off <= OFF_TAG_END))
        else $error("Header offset ran past the data tag.");

    a_size_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIZE) |-> (r_off <= OFF_SIZE_END))
        else $error("Size byte index out of range.");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && c_plast) |=> (r_phase == PH_DONE))
        else $error("Final payload byte did not close the data chunk.");
`endif

endmodule

// ===== src/wavhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// WAV header parser output stage
// Result register that holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module wavhp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_valid,
    output logic                o_load,
    input  wavhp_pkg::t_result  i_result,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wavhp_pkg::t_result  o_result
);
    import wavhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_load      = i_load_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/WAV byte stream, captures format fields and passes the
// data chunk payload on with a last flag.
// ----------------------------------------------------------------------------
// The input channel takes one file byte per beat, with a start mark on the
// first byte of each file; a beat is taken when i_in_valid is high and
// o_in_stall is low. Each accepted byte produces exactly one result beat on
// the output channel, taken when o_out_valid is high and i_out_stall is low.
// The result carries a status code, the payload byte and last flag, and the
// captured channel count, sample rate, bits per sample, data size and
// format code as they stand after that byte.
// Each byte passes the input register, then the result register. Throughput
// is one byte per cycle while the receiver does not stall, set by the single
// parse stage between those registers. When the receiver stalls, the result
// register holds its beat, the input register fills, then o_in_stall rises.
// Reset clears the parse to the start of a file and sets the search limit
// to 100. The search limit is written through i_cfg_valid / o_cfg_ready,
// which is always ready; write it only while no byte is in flight.
// ----------------------------------------------------------------------------
module wav_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_start_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_bits_per_sample,
    output logic [31:0] o_data_size,
    output logic [1:0]  o_format_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_search_limit
);
    import wavhp_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    advance;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    wavhp_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_file_byte     (i_file_byte),
        .i_start_of_file (i_start_of_file),
        .i_take          (advance),
        .o_valid         (item_valid),
        .o_item          (item)
    );

    wavhp_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_search_limit (i_cfg_search_limit),
        .i_advance          (advance),
        .i_item             (item),
        .o_result           (core_result)
    );

    wavhp_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (item_valid),
        .o_load       (advance),
        .i_result     (core_result),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (out_result)
    );

    assign o_status          = out_result.status;
    assign o_payload_byte    = out_result.payload_byte;
    assign o_payload_last    = out_result.payload_last;
    assign o_channel_count   = out_result.channel_count;
    assign o_sample_rate     = out_result.sample_rate;
    assign o_bits_per_sample = out_result.bits_per_sample;
    assign o_data_size       = out_result.data_size;
    assign o_format_code     = out_result.format_code;

endmodule
